>>> sv/nps_pkg.sv
`timescale 1ns / 1ps

package nps_pkg;

  localparam int unsigned MaxEntriesDef = 16;
  localparam int unsigned CoordBits     = 24;
  localparam int unsigned IndexW        = 4;
  localparam int unsigned DistW         = 51;
  localparam int unsigned SqW           = 2 * CoordBits;
  localparam int unsigned ActiveW       = 5;
  localparam int unsigned ApbAddrW      = 3;
  localparam int unsigned ApbDataW      = 32;

  localparam logic [ActiveW-1:0] ActiveReset = ActiveW'(1);

  // Register index, taken from the word address.
  localparam logic [0:0] REG_ACTIVE = 1'b0;

  typedef enum logic [0:0] {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_SCAN  = 2'd1,
    ST_DRAIN = 2'd2,
    ST_HOLD  = 2'd3
  } seq_state_e;

  typedef struct packed {
    logic issue;
    logic last;
  } scan_ctl_t;

endpackage

>>> sv/nps_in_if.sv
`timescale 1ns / 1ps

interface nps_in_if import nps_pkg::*; ();

  logic                        valid;
  logic                        ready;
  logic                        opcode;
  logic [IndexW-1:0]           entry_index;
  logic signed [CoordBits-1:0] coord_x;
  logic signed [CoordBits-1:0] coord_z;

  modport source (
    output valid, opcode, entry_index, coord_x, coord_z,
    input  ready
  );

  modport sink (
    input  valid, opcode, entry_index, coord_x, coord_z,
    output ready
  );

endinterface

>>> sv/nps_out_if.sv
`timescale 1ns / 1ps

interface nps_out_if import nps_pkg::*; ();

  logic              valid;
  logic              ready;
  logic [IndexW-1:0] nearest_index;
  logic [DistW-1:0]  min_distance_sq;

  modport source (
    output valid, nearest_index, min_distance_sq,
    input  ready
  );

  modport sink (
    input  valid, nearest_index, min_distance_sq,
    output ready
  );

endinterface

>>> sv/nps_point_mem.sv
`timescale 1ns / 1ps

module nps_point_mem import nps_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = MaxEntriesDef,
  localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 wr_en_i,
  input  logic [AW-1:0]        wr_addr_i,
  input  logic [CoordBits-1:0] wr_x_i,
  input  logic [CoordBits-1:0] wr_z_i,
  input  scan_ctl_t            rd_ctl_i,
  input  logic [AW-1:0]        rd_addr_i,
  output scan_ctl_t            rd_ctl_o,
  output logic [AW-1:0]        rd_idx_o,
  output logic [CoordBits-1:0] rd_x_o,
  output logic [CoordBits-1:0] rd_z_o
);

  logic [CoordBits-1:0] mem_x_q [MAX_ENTRIES];
  logic [CoordBits-1:0] mem_z_q [MAX_ENTRIES];
  logic [CoordBits-1:0] rd_x_q, rd_z_q;
  logic [AW-1:0]        rd_idx_q;
  scan_ctl_t            rd_ctl_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_x_q[wr_addr_i] <= wr_x_i;
      mem_z_q[wr_addr_i] <= wr_z_i;
    end
    rd_x_q   <= mem_x_q[rd_addr_i];
    rd_z_q   <= mem_z_q[rd_addr_i];
    rd_idx_q <= rd_addr_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ctl_q <= '0;
    end else begin
      rd_ctl_q <= rd_ctl_i;
    end
  end

  assign rd_ctl_o = rd_ctl_q;
  assign rd_idx_o = rd_idx_q;
  assign rd_x_o   = rd_x_q;
  assign rd_z_o   = rd_z_q;

endmodule

>>> sv/nps_dist_unit.sv
`timescale 1ns / 1ps

module nps_dist_unit import nps_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = MaxEntriesDef,
  localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [CoordBits-1:0] qx_i,
  input  logic [CoordBits-1:0] qz_i,
  input  scan_ctl_t            ctl_i,
  input  logic [AW-1:0]        idx_i,
  input  logic [CoordBits-1:0] px_i,
  input  logic [CoordBits-1:0] pz_i,
  output scan_ctl_t            ctl_o,
  output logic [AW-1:0]        idx_o,
  output logic [DistW-1:0]     dist_o
);

  logic [CoordBits:0]   diff_x, diff_z, mag_x, mag_z;
  logic [CoordBits-1:0] abs_x_q, abs_z_q;
  logic [SqW-1:0]       sq_x_q, sq_z_q;
  logic [DistW-1:0]     sum_q;
  logic [AW-1:0]        idx1_q, idx2_q, idx3_q;
  scan_ctl_t            ctl1_q, ctl2_q, ctl3_q;

  // Exact signed differences, one bit wider than the coordinates.
  always_comb begin
    diff_x = {qx_i[CoordBits-1], qx_i} - {px_i[CoordBits-1], px_i};
    diff_z = {qz_i[CoordBits-1], qz_i} - {pz_i[CoordBits-1], pz_i};
    mag_x  = diff_x[CoordBits] ? (~diff_x + 1'b1) : diff_x;
    mag_z  = diff_z[CoordBits] ? (~diff_z + 1'b1) : diff_z;
  end

  always_ff @(posedge clk_i) begin
    abs_x_q <= mag_x[CoordBits-1:0];
    abs_z_q <= mag_z[CoordBits-1:0];
    sq_x_q  <= abs_x_q * abs_x_q;
    sq_z_q  <= abs_z_q * abs_z_q;
    sum_q   <= DistW'(sq_x_q) + DistW'(sq_z_q);
    idx1_q  <= idx_i;
    idx2_q  <= idx1_q;
    idx3_q  <= idx2_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
      ctl2_q <= '0;
      ctl3_q <= '0;
    end else begin
      ctl1_q <= ctl_i;
      ctl2_q <= ctl1_q;
      ctl3_q <= ctl2_q;
    end
  end

  assign ctl_o  = ctl3_q;
  assign idx_o  = idx3_q;
  assign dist_o = sum_q;

endmodule

>>> sv/nps_seq.sv
`timescale 1ns / 1ps

module nps_seq import nps_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = MaxEntriesDef,
  localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_query_i,
  input  logic [ActiveW-1:0] active_i,
  input  logic               out_free_i,
  input  scan_ctl_t          res_ctl_i,
  input  logic [AW-1:0]      res_idx_i,
  input  logic [DistW-1:0]   res_dist_i,
  output logic               in_ready_o,
  output scan_ctl_t          rd_ctl_o,
  output logic [AW-1:0]      rd_addr_o,
  output logic               out_load_o,
  output logic [AW-1:0]      best_idx_o,
  output logic [DistW-1:0]   best_dist_o
);

  seq_state_e       state_q, state_d;
  logic [CW-1:0]    count_q, count_d;
  logic [AW-1:0]    entry_q, entry_d;
  logic [AW-1:0]    best_idx_q, best_idx_d;
  logic [DistW-1:0] best_dist_q, best_dist_d;
  logic             is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= CW'(1);
      entry_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      entry_q <= entry_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_idx_q  <= best_idx_d;
    best_dist_q <= best_dist_d;
  end

  // Only a strictly smaller distance replaces the best, so ties keep the lower index.
  always_comb begin
    best_idx_d  = best_idx_q;
    best_dist_d = best_dist_q;
    if (res_ctl_i.issue && ((res_idx_i == '0) || (res_dist_i < best_dist_q))) begin
      best_idx_d  = res_idx_i;
      best_dist_d = res_dist_i;
    end
  end

  assign is_last = (entry_q == AW'(count_q - CW'(1)));

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    entry_d    = entry_q;
    in_ready_o = 1'b0;
    rd_ctl_o   = '0;
    out_load_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i && in_query_i) begin
          entry_d = '0;
          if (active_i == '0) begin
            count_d = CW'(1);
          end else if (int'(active_i) > MAX_ENTRIES) begin
            count_d = CW'(MAX_ENTRIES);
          end else begin
            count_d = CW'(active_i);
          end
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        rd_ctl_o.issue = 1'b1;
        rd_ctl_o.last  = is_last;
        if (is_last) begin
          state_d = ST_DRAIN;
        end else begin
          entry_d = entry_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (res_ctl_i.issue && res_ctl_i.last) begin
          if (out_free_i) begin
            out_load_o = 1'b1;
            state_d    = ST_IDLE;
          end else begin
            state_d = ST_HOLD;
          end
        end
      end
      ST_HOLD: begin
        if (out_free_i) begin
          out_load_o = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign rd_addr_o   = entry_q;
  assign best_idx_o  = best_idx_d;
  assign best_dist_o = best_dist_d;

endmodule

>>> sv/nearest_point_search_core.sv
`timescale 1ns / 1ps
// A load item goes into the point table and the block stays ready for the next item.
// A query scans N active entries (active_entries clamped to 1..MAX_ENTRIES) through the
// single distance pipeline, one table entry per cycle, into the output register, which
// may wait for out_o.ready; no new item is taken until the result is loaded there.
// Reset sets active_entries to 1; the point table is undefined until loaded.

module nearest_point_search_core import nps_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = MaxEntriesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  nps_in_if.sink              in_i,
  nps_out_if.source           out_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  logic [ActiveW-1:0]   active_q;
  logic [CoordBits-1:0] qx_q, qz_q;
  logic                 out_valid_q;
  logic [IndexW-1:0]    out_idx_q;
  logic [DistW-1:0]     out_dist_q;

  logic                 in_ready, accept, is_query, load_en, out_free, out_load;
  scan_ctl_t            rd_ctl, mem_ctl, res_ctl;
  logic [AW-1:0]        rd_addr, mem_idx, res_idx, best_idx;
  logic [CoordBits-1:0] mem_x, mem_z;
  logic [DistW-1:0]     res_dist, best_dist;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_ACTIVE) ? {{(ApbDataW - ActiveW){1'b0}}, active_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= ActiveReset;
    end else if (psel && penable && pwrite && (paddr[2] == REG_ACTIVE)) begin
      active_q <= pwdata[ActiveW-1:0];
    end
  end

  assign in_i.ready = in_ready;
  assign accept     = in_i.valid && in_ready;
  assign is_query   = (in_i.opcode == OP_QUERY);
  assign load_en    = accept && !is_query && (int'(in_i.entry_index) < MAX_ENTRIES);

  always_ff @(posedge clk_i) begin
    if (accept && is_query) begin
      qx_q <= in_i.coord_x;
      qz_q <= in_i.coord_z;
    end
  end

  nps_point_mem #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (load_en),
    .wr_addr_i (AW'(in_i.entry_index)),
    .wr_x_i    (in_i.coord_x),
    .wr_z_i    (in_i.coord_z),
    .rd_ctl_i  (rd_ctl),
    .rd_addr_i (rd_addr),
    .rd_ctl_o  (mem_ctl),
    .rd_idx_o  (mem_idx),
    .rd_x_o    (mem_x),
    .rd_z_o    (mem_z)
  );

  nps_dist_unit #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_dist (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .qx_i   (qx_q),
    .qz_i   (qz_q),
    .ctl_i  (mem_ctl),
    .idx_i  (mem_idx),
    .px_i   (mem_x),
    .pz_i   (mem_z),
    .ctl_o  (res_ctl),
    .idx_o  (res_idx),
    .dist_o (res_dist)
  );

  nps_seq #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_query_i  (is_query),
    .active_i    (active_q),
    .out_free_i  (out_free),
    .res_ctl_i   (res_ctl),
    .res_idx_i   (res_idx),
    .res_dist_i  (res_dist),
    .in_ready_o  (in_ready),
    .rd_ctl_o    (rd_ctl),
    .rd_addr_o   (rd_addr),
    .out_load_o  (out_load),
    .best_idx_o  (best_idx),
    .best_dist_o (best_dist)
  );

  assign out_free = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_idx_q  <= IndexW'(best_idx);
      out_dist_q <= best_dist;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.nearest_index   = out_idx_q;
  assign out_o.min_distance_sq = out_dist_q;

endmodule
